FILE: hdl/sbfd_pkg.sv
// ----------------------------------------------------------------------------
// sbfd_pkg
// Shared constants and types of the SBUS-style frame decoder.
// ----------------------------------------------------------------------------
package sbfd_pkg;

  // Field widths.
  localparam int ByteW   = 8;
  localparam int ChanW   = 11;
  localparam int PulseW  = 16;
  localparam int OffsetW = 12;
  localparam int CfgIdxW = 8;
  localparam int CfgDatW = 12;

  // Frame geometry.
  localparam int FrameBytesDef = 25;
  localparam int NumChan       = 7;
  localparam int FirstChanByte = 1;
  localparam int LastChanByte  = 10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegStartByte   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegFooterMask  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegFooterValue = 8'd2;
  localparam logic [CfgIdxW-1:0] RegPulseOffset = 8'd3;

  // Register reset values.
  localparam logic [ByteW-1:0]   StartByteRst   = 8'h0f;
  localparam logic [ByteW-1:0]   FooterMaskRst  = 8'h0f;
  localparam logic [ByteW-1:0]   FooterValueRst = 8'h04;
  localparam logic [OffsetW-1:0] PulseOffsetRst = 12'd880;

  typedef logic [ChanW-1:0] chan_t;

endpackage

FILE: hdl/sbfd_byte_if.sv
// ----------------------------------------------------------------------------
// sbfd_byte_if
// Received byte channel: valid, ready and one serial byte.
// ----------------------------------------------------------------------------
interface sbfd_byte_if;
  logic                       valid;
  logic                       ready;
  logic [sbfd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/sbfd_result_if.sv
// ----------------------------------------------------------------------------
// sbfd_result_if
// Decoded frame channel: seven channels and the scaled pulse of channel 0.
// ----------------------------------------------------------------------------
interface sbfd_result_if;
  logic                        valid;
  logic                        ready;
  sbfd_pkg::chan_t             chan0;
  sbfd_pkg::chan_t             chan1;
  sbfd_pkg::chan_t             chan2;
  sbfd_pkg::chan_t             chan3;
  sbfd_pkg::chan_t             chan4;
  sbfd_pkg::chan_t             chan5;
  sbfd_pkg::chan_t             chan6;
  logic [sbfd_pkg::PulseW-1:0] pulse_x8;

  modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                  output chan4, output chan5, output chan6, output pulse_x8, input ready);
  modport sink   (input valid, input chan0, input chan1, input chan2, input chan3,
                  input chan4, input chan5, input chan6, input pulse_x8, output ready);
endinterface

FILE: hdl/sbfd_cfg_if.sv
// ----------------------------------------------------------------------------
// sbfd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sbfd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sbfd_pkg::CfgIdxW-1:0] index;
  logic [sbfd_pkg::CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Byte-serial decoder for the first seven channels of an SBUS-style frame.
// ----------------------------------------------------------------------------
// The decoder takes one received byte per clock cycle and never stalls the
// byte stream except when a decoded item is waiting at the output and the
// output is not being taken. A frame opens only on a byte equal to
// sync_byte; other bytes seen between frames are dropped. A frame is
// FRAME_BYTES bytes long, and its last byte, ANDed with footer_mask, must
// equal footer_value; otherwise the frame yields nothing. A good frame yields
// one item, which appears on the result channel in the cycle after its last
// byte is accepted. It carries channels 0 to 6 (11-bit little-endian fields
// packed from bytes 1 to 10) and pulse_x8 = chan0 * 5 + pulse_offset * 8,
// the pulse value with three fraction bits. The rate is one byte per cycle,
// set by the single result register: a byte is accepted whenever that
// register is empty or is being emptied in the same cycle. Configuration
// writes are always taken, and writes to indexes above 3 are ignored.
// ----------------------------------------------------------------------------
module sbus_frame_decoder #(
  parameter int FRAME_BYTES = sbfd_pkg::FrameBytesDef
) (
  input  logic          clk,
  input  logic          rst,
  sbfd_byte_if.sink     rx,
  sbfd_result_if.source res,
  sbfd_cfg_if.sink      cfg
);

  // Width of the byte position counter, enough for positions 0 to FRAME_BYTES-1.
  localparam int PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);
  localparam int StreamW = (sbfd_pkg::LastChanByte - sbfd_pkg::FirstChanByte + 1)
                           * sbfd_pkg::ByteW;

  // Configuration registers.
  logic [sbfd_pkg::ByteW-1:0]   sync_byte;
  logic [sbfd_pkg::ByteW-1:0]   footer_mask;
  logic [sbfd_pkg::ByteW-1:0]   footer_value;
  logic [sbfd_pkg::OffsetW-1:0] pulse_offset;

  // Frame state. A non-zero position means a frame is being collected, so no
  // separate in-frame flag is kept.
  logic [PosW-1:0]            byte_position;
  logic [sbfd_pkg::ByteW-1:0] frame_store [sbfd_pkg::FirstChanByte:sbfd_pkg::LastChanByte];

  // Result register.
  logic                       res_valid;
  sbfd_pkg::chan_t            chan_reg [sbfd_pkg::NumChan];
  logic [sbfd_pkg::PulseW-1:0] pulse_reg;

  logic            rx_take;
  logic            frame_byte;
  logic            last_byte;
  logic            footer_ok;
  logic            res_load;
  logic [StreamW-1:0] stream;
  sbfd_pkg::chan_t chan_next [sbfd_pkg::NumChan];
  logic [sbfd_pkg::PulseW-1:0] pulse_next;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, a write lands in the same cycle.
  // ---------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte    <= sbfd_pkg::StartByteRst;
      footer_mask  <= sbfd_pkg::FooterMaskRst;
      footer_value <= sbfd_pkg::FooterValueRst;
      pulse_offset <= sbfd_pkg::PulseOffsetRst;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        sbfd_pkg::RegStartByte:   sync_byte    <= cfg.data[sbfd_pkg::ByteW-1:0];
        sbfd_pkg::RegFooterMask:  footer_mask  <= cfg.data[sbfd_pkg::ByteW-1:0];
        sbfd_pkg::RegFooterValue: footer_value <= cfg.data[sbfd_pkg::ByteW-1:0];
        sbfd_pkg::RegPulseOffset: pulse_offset <= cfg.data[sbfd_pkg::OffsetW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Byte intake. A byte is accepted whenever the result register is free or
  // is being emptied in this cycle, so bytes keep flowing back to back.
  // ---------------------------------------------------------------------------
  assign rx.ready = !res_valid || res.ready;
  assign rx_take  = rx.valid && rx.ready;

  // At position zero only the start byte belongs to a frame; after that every
  // byte does.
  assign frame_byte = (byte_position != '0) || (rx.rx_byte == sync_byte);
  assign last_byte  = (byte_position == LastPos);
  assign footer_ok  = ((rx.rx_byte & footer_mask) == footer_value);
  assign res_load   = rx_take && frame_byte && last_byte && footer_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (rx_take && frame_byte) begin
      byte_position <= last_byte ? '0 : byte_position + PosW'(1);
    end
  end

  // Only bytes 1 to 10 carry the seven channels; the start byte and the
  // bytes after them are not kept.
  always_ff @(posedge clk) begin
    if (rx_take) begin
      for (int i = sbfd_pkg::FirstChanByte; i <= sbfd_pkg::LastChanByte; i++) begin
        if (byte_position == PosW'(i)) begin
          frame_store[i] <= rx.rx_byte;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Unpacking. Bytes 1 to 10 form one little-endian bit stream, and channel k
  // occupies bits 11k to 11k+10 of it. The stored bytes are complete long
  // before the last byte arrives, so the fields are simple bit selects.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = sbfd_pkg::FirstChanByte; i <= sbfd_pkg::LastChanByte; i++) begin
      stream[(i - sbfd_pkg::FirstChanByte) * sbfd_pkg::ByteW +: sbfd_pkg::ByteW] =
        frame_store[i];
    end
    for (int k = 0; k < sbfd_pkg::NumChan; k++) begin
      chan_next[k] = stream[k * sbfd_pkg::ChanW +: sbfd_pkg::ChanW];
    end
  end

  // Pulse in eighths: chan0 * 5 is chan0 * 4 + chan0, and the offset is
  // shifted up by three fraction bits. The sum stays below 2^16.
  assign pulse_next = {3'b000, chan_next[0], 2'b00}
                    + {5'b00000, chan_next[0]}
                    + {1'b0, pulse_offset, 3'b000};

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      chan_reg  <= chan_next;
      pulse_reg <= pulse_next;
    end
  end

  assign res.valid    = res_valid;
  assign res.chan0    = chan_reg[0];
  assign res.chan1    = chan_reg[1];
  assign res.chan2    = chan_reg[2];
  assign res.chan3    = chan_reg[3];
  assign res.chan4    = chan_reg[4];
  assign res.chan5    = chan_reg[5];
  assign res.chan6    = chan_reg[6];
  assign res.pulse_x8 = pulse_reg;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SBUS-style frame decoder. A short table of
// directed frames and stray bytes comes first, then phases of random frames
// under several register settings. Every decoded item is compared, field by
// field, with a directed row's written-in outcome or a local decoder's output.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FrameBytes  = sbfd_pkg::FrameBytesDef;
  localparam int StoreBytes  = sbfd_pkg::LastChanByte + 1;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 4;
  localparam int PhaseBytes  = 300;

  // One decoded frame as it leaves the block.
  typedef struct packed {
    sbfd_pkg::chan_t [sbfd_pkg::NumChan-1:0] chan;
    logic [sbfd_pkg::PulseW-1:0]             pulse_x8;
  } frame_item_t;

  // How the body bytes of a directed or random frame are filled.
  typedef enum logic [1:0] {BODY_ZERO, BODY_ONES, BODY_COUNT, BODY_RAND} body_e;

  // One row of the directed table. A row whose lead byte is not the start
  // byte is a single stray byte; otherwise it is a whole frame. Where known
  // is set, the outcome is written into the row rather than predicted.
  typedef struct {
    logic [sbfd_pkg::ByteW-1:0]  lead;
    body_e                       body;
    logic [sbfd_pkg::ByteW-1:0]  footer;
    bit                          known;
    bit                          hit;
    sbfd_pkg::chan_t             chan;
    logic [sbfd_pkg::PulseW-1:0] pulse_x8;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  sbfd_byte_if   rx_if ();
  sbfd_result_if res_if ();
  sbfd_cfg_if    cfg_if ();

  sbus_frame_decoder #(
    .FRAME_BYTES(FrameBytes)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .rx (rx_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the register file, updated as each write is accepted.
  logic [sbfd_pkg::ByteW-1:0]   cur_sync_byte    = sbfd_pkg::StartByteRst;
  logic [sbfd_pkg::ByteW-1:0]   cur_footer_mask  = sbfd_pkg::FooterMaskRst;
  logic [sbfd_pkg::ByteW-1:0]   cur_footer_value = sbfd_pkg::FooterValueRst;
  logic [sbfd_pkg::OffsetW-1:0] cur_pulse_offset = sbfd_pkg::PulseOffsetRst;

  // Local copy of the decoder state.
  logic [4:0]                 frame_pos = '0;
  bit                         frame_open = 1'b0;
  logic [sbfd_pkg::ByteW-1:0] frame_bytes [StoreBytes];

  // Decoded items that are due from the block, oldest first.
  frame_item_t pending_frames [$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;
  bit          gaps_on = 1'b1;

  frame_item_t seen_frame;
  frame_item_t want_frame;

  // The directed table runs under the reset register values: start byte
  // 0x0F, footer mask 0x0F, footer value 0x04 and a pulse offset of 880.
  directed_row_t directed [10] = '{
    // Stray bytes at the frame boundary are dropped without a result.
    '{8'h00, BODY_ZERO,  8'h00, 1'b1, 1'b0, 11'd0,    16'd0},
    '{8'hFF, BODY_ZERO,  8'h00, 1'b1, 1'b0, 11'd0,    16'd0},
    // All-zero channels give the bare offset, eight times 880.
    '{8'h0F, BODY_ZERO,  8'h04, 1'b1, 1'b1, 11'd0,    16'd7040},
    // All-ones channels; the footer passes because its high nibble is masked.
    '{8'h0F, BODY_ONES,  8'hF4, 1'b1, 1'b1, 11'd2047, 16'd17275},
    // Footer mismatch: the whole frame is thrown away.
    '{8'h0F, BODY_ONES,  8'h05, 1'b1, 1'b0, 11'd0,    16'd0},
    '{8'h0E, BODY_ZERO,  8'h00, 1'b1, 1'b0, 11'd0,    16'd0},
    // A counting body holds the start byte mid-frame, which must not restart.
    '{8'h0F, BODY_COUNT, 8'h04, 1'b0, 1'b0, 11'd0,    16'd0},
    '{8'h0F, BODY_RAND,  8'hA4, 1'b0, 1'b0, 11'd0,    16'd0},
    '{8'h0F, BODY_RAND,  8'h00, 1'b1, 1'b0, 11'd0,    16'd0},
    '{8'h0F, BODY_RAND,  8'h34, 1'b0, 1'b0, 11'd0,    16'd0}
  };

  // Advances the local decoder by one accepted byte. It returns 1 when that
  // byte closes a frame whose footer passes, with the decoded item in item.
  function automatic bit decode_byte(input logic [sbfd_pkg::ByteW-1:0] b,
                                     output frame_item_t item);
    logic [8*(sbfd_pkg::LastChanByte-sbfd_pkg::FirstChanByte+1)-1:0] chan_bits;
    int unsigned pulse;
    item = '0;
    if (frame_pos == 0) frame_open = (b == cur_sync_byte);
    if (!frame_open) return 1'b0;
    if (frame_pos < StoreBytes) frame_bytes[frame_pos] = b;
    frame_pos = frame_pos + 5'd1;
    if (frame_pos < FrameBytes) return 1'b0;
    frame_pos = '0;
    frame_open = 1'b0;
    if ((b & cur_footer_mask) != cur_footer_value) return 1'b0;
    // Bytes 1 to 10 form one little-endian bit stream, eleven bits a channel.
    for (int i = sbfd_pkg::FirstChanByte; i <= sbfd_pkg::LastChanByte; i++) begin
      chan_bits[8*(i-sbfd_pkg::FirstChanByte) +: 8] = frame_bytes[i];
    end
    for (int k = 0; k < sbfd_pkg::NumChan; k++) begin
      item.chan[k] = chan_bits[sbfd_pkg::ChanW*k +: sbfd_pkg::ChanW];
    end
    pulse = item.chan[0] * 5 + cur_pulse_offset * 8;
    item.pulse_x8 = sbfd_pkg::PulseW'(pulse);
    return 1'b1;
  endfunction

  function automatic logic [sbfd_pkg::ByteW-1:0] body_byte(input body_e mode, input int idx);
    case (mode)
      BODY_ZERO:  return 8'h00;
      BODY_ONES:  return 8'hFF;
      BODY_COUNT: return idx[7:0];
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $realtime, what);
  endfunction

  // Offers one byte, waits until the block takes it and runs the local
  // decoder on it. Ready is read at the falling edge, where it is settled
  // for the rising edge that follows. Valid is left high for the next item.
  task automatic send_byte(input logic [sbfd_pkg::ByteW-1:0] b, output bit hit,
                           output frame_item_t item);
    bit took;
    if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do begin
      @(negedge clk);
      took = rx_if.ready;
      @(posedge clk);
    end while (!took);
    hit = decode_byte(b, item);
  endtask

  task automatic feed_byte(input logic [sbfd_pkg::ByteW-1:0] b);
    bit hit;
    frame_item_t item;
    send_byte(b, hit, item);
    if (hit) pending_frames.push_back(item);
  endtask

  // Completes any frame that is still open with random bytes, so that the
  // next frame or register write starts at the frame boundary.
  task automatic flush_frame();
    while (frame_pos != 0) feed_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(input logic [sbfd_pkg::CfgIdxW-1:0] idx,
                           input logic [sbfd_pkg::CfgDatW-1:0] val);
    bit took;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do begin
      @(negedge clk);
      took = cfg_if.ready;
      @(posedge clk);
    end while (!took);
    // Data bits above a register's width are dropped, unknown indexes ignored.
    case (idx)
      sbfd_pkg::RegStartByte:   cur_sync_byte    = val[sbfd_pkg::ByteW-1:0];
      sbfd_pkg::RegFooterMask:  cur_footer_mask  = val[sbfd_pkg::ByteW-1:0];
      sbfd_pkg::RegFooterValue: cur_footer_value = val[sbfd_pkg::ByteW-1:0];
      sbfd_pkg::RegPulseOffset: cur_pulse_offset = val[sbfd_pkg::OffsetW-1:0];
      default: ;
    endcase
  endtask

  // Writes a complete setting. A write to an index beyond the register file
  // goes first each time, and must leave every register as it was.
  task automatic program_regs(input logic [sbfd_pkg::CfgDatW-1:0] start, mask, value,
                              offset);
    write_reg(sbfd_pkg::CfgIdxW'($urandom_range(4, 255)),
              sbfd_pkg::CfgDatW'($urandom_range(0, 4095)));
    write_reg(sbfd_pkg::RegStartByte, start);
    write_reg(sbfd_pkg::RegFooterMask, mask);
    write_reg(sbfd_pkg::RegFooterValue, value);
    write_reg(sbfd_pkg::RegPulseOffset, offset);
    cfg_if.valid <= 1'b0;
  endtask

  // Ends a phase: closes any open frame, parks the byte channel and waits
  // until every decoded item due has arrived, then allows the block a little
  // margin before the registers change.
  task automatic finish_phase();
    flush_frame();
    rx_if.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Random traffic: mostly well-formed frames with random content, some with
  // a random footer that will usually fail, and a little stray noise between
  // frames. Only frame bytes count towards the size of the phase.
  task automatic random_phase(input int target);
    int sent;
    int kind;
    body_e mode;
    logic [sbfd_pkg::ByteW-1:0] foot;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 99);
      gaps_on = 1'($urandom_range(0, 1));
      if (kind < 88) begin
        flush_frame();
        case ($urandom_range(0, 9))
          0:       mode = BODY_ZERO;
          1:       mode = BODY_ONES;
          default: mode = BODY_RAND;
        endcase
        if (kind < 76) begin
          foot = (8'($urandom_range(0, 255)) & ~cur_footer_mask) | cur_footer_value;
        end else begin
          foot = 8'($urandom_range(0, 255));
        end
        feed_byte(cur_sync_byte);
        for (int i = 1; i < FrameBytes - 1; i++) feed_byte(body_byte(mode, i));
        feed_byte(foot);
        sent += FrameBytes;
      end else begin
        repeat ($urandom_range(1, 4)) feed_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // The result side stalls in random bursts, and not at all once the closing
  // phase has begun.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left   <= $urandom_range(0, 13);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Every item taken from the result channel is matched against the oldest
  // item still due. Values are read at the rising edge, before the block
  // updates them.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      seen_frame.chan[0] = res_if.chan0;
      seen_frame.chan[1] = res_if.chan1;
      seen_frame.chan[2] = res_if.chan2;
      seen_frame.chan[3] = res_if.chan3;
      seen_frame.chan[4] = res_if.chan4;
      seen_frame.chan[5] = res_if.chan5;
      seen_frame.chan[6] = res_if.chan6;
      seen_frame.pulse_x8 = res_if.pulse_x8;
      if (pending_frames.size() == 0) begin
        note_mismatch($sformatf("unexpected item, chan0 %0d pulse_x8 %0d",
                                seen_frame.chan[0], seen_frame.pulse_x8));
      end else begin
        want_frame = pending_frames.pop_front();
        for (int k = 0; k < sbfd_pkg::NumChan; k++) begin
          if (seen_frame.chan[k] !== want_frame.chan[k]) begin
            note_mismatch($sformatf("chan%0d expected %0d, got %0d",
                                    k, want_frame.chan[k], seen_frame.chan[k]));
          end
        end
        if (seen_frame.pulse_x8 !== want_frame.pulse_x8) begin
          note_mismatch($sformatf("pulse_x8 expected %0d, got %0d",
                                  want_frame.pulse_x8, seen_frame.pulse_x8));
        end
      end
    end
  end

  // Watchdog: a hung handshake or an item that never comes ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int n;
    logic [sbfd_pkg::ByteW-1:0] b;
    bit hit;
    frame_item_t item;
    frame_item_t typed;
    logic [sbfd_pkg::CfgDatW-1:0] mask;

    rst           = 1'b1;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    res_if.ready  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset values. For a row with a written-in
    // outcome, that outcome takes the place of the prediction on its last
    // byte; all earlier bytes of a row cannot complete a frame.
    foreach (directed[r]) begin
      n = (directed[r].lead == cur_sync_byte) ? FrameBytes : 1;
      for (int i = 0; i < n; i++) begin
        if (i == 0) b = directed[r].lead;
        else if (i == n - 1) b = directed[r].footer;
        else b = body_byte(directed[r].body, i);
        send_byte(b, hit, item);
        if (i == n - 1 && directed[r].known) begin
          if (directed[r].hit) begin
            for (int k = 0; k < sbfd_pkg::NumChan; k++) typed.chan[k] = directed[r].chan;
            typed.pulse_x8 = directed[r].pulse_x8;
            pending_frames.push_back(typed);
          end
        end else if (hit) begin
          pending_frames.push_back(item);
        end
      end
    end
    finish_phase();

    // Lowest extremes: start byte zero (written with junk in the upper data
    // bits), an empty mask so that every footer passes, and a zero offset.
    program_regs(12'hF00, 12'h000, 12'h000, 12'h000);
    random_phase(PhaseBytes);
    finish_phase();

    // Highest extremes: all-ones start byte and footer, and the largest
    // offset, which together with all-ones channels gives the top pulse value.
    program_regs(12'h0FF, 12'h0FF, 12'h0FF, 12'hFFF);
    random_phase(PhaseBytes);
    finish_phase();

    // Random settings; the footer value is kept within the mask so that
    // well-formed frames can pass.
    repeat (2) begin
      mask = sbfd_pkg::CfgDatW'($urandom);
      program_regs(sbfd_pkg::CfgDatW'($urandom), mask,
                   sbfd_pkg::CfgDatW'($urandom) & {4'hF, mask[7:0]},
                   sbfd_pkg::CfgDatW'($urandom));
      random_phase(PhaseBytes);
      finish_phase();
    end

    // Closing phase back at the reset values, with no idling on either side.
    calm = 1'b1;
    program_regs({4'h0, sbfd_pkg::StartByteRst}, {4'h0, sbfd_pkg::FooterMaskRst},
                 {4'h0, sbfd_pkg::FooterValueRst}, sbfd_pkg::PulseOffsetRst);
    random_phase(PhaseBytes);
    finish_phase();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sbfd_pkg.sv
hdl/sbfd_byte_if.sv
hdl/sbfd_result_if.sv
hdl/sbfd_cfg_if.sv
hdl/sbus_frame_decoder.sv
tb/testbench.sv
